// File: hdl/sad_pkg.sv
// Shared types and constants for the stereo SAD disparity block.
// No dependencies; every other file of the block imports this package.
package sad_pkg;

    // default sizes
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int WINDOW_DEF    = 7;
    localparam int SEARCH_DEF    = 56;

    // fixed field widths
    localparam int PIX_W      = 8;
    localparam int DISP_W     = 6;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 10;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int DIM_CMP_W  = 13;

    // frame limits and register reset values
    localparam int MIN_DIM      = 16;
    localparam int MAX_HEIGHT   = 4096;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CAND,
        ST_READ,
        ST_ACC,
        ST_NEXT,
        ST_RESULT
    } sad_state_t;

    // controller to datapath
    typedef struct packed {
        logic start_search;
        logic cand_init;
        logic rd;
        logic acc;
        logic cand_done;
        logic load_out;
    } sad_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_out;
        logic need_match;
        logic last_px;
        logic last_cand;
        logic out_busy;
    } sad_sts_t;

endpackage

// File: hdl/sad_if.sv
// Handshake channel interfaces: pixel input, disparity result, config write.
// Depends on sad_pkg for field widths.
interface sad_pix_if
    import sad_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pix_l;
    logic [PIX_W-1:0] pix_r;

    modport source (output valid, pix_l, pix_r, input ready);
    modport sink   (input valid, pix_l, pix_r, output ready);
endinterface

interface sad_res_if
    import sad_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DISP_W-1:0] disparity;
    logic [ROW_W-1:0]  out_row;
    logic [COL_W-1:0]  out_col;

    modport source (output valid, disparity, out_row, out_col, input ready);
    modport sink   (input valid, disparity, out_row, out_col, output ready);
endinterface

interface sad_cfg_if
    import sad_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/sad_ctrl.sv
// Sequencer for the SAD search: walks candidates and block pixels.
// Depends on sad_pkg (state, command and status types).
module sad_ctrl
    import sad_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  sad_sts_t sts,
    output sad_cmd_t cmd
);

    sad_state_t state_reg;
    sad_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!sts.need_out)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.need_match)
                begin
                    state_next = ST_CAND;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_CAND:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                state_next = sts.last_px ? ST_NEXT : ST_READ;
            end
            ST_NEXT:
            begin
                state_next = sts.last_cand ? ST_RESULT : ST_CAND;
            end
            ST_RESULT:
            begin
                if (!sts.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_CHECK:
            begin
                cmd.start_search = sts.need_out & sts.need_match;
            end
            ST_CAND:
            begin
                cmd.cand_init = 1'b1;
            end
            ST_READ:
            begin
                cmd.rd = 1'b1;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
            end
            ST_NEXT:
            begin
                cmd.cand_done = 1'b1;
            end
            ST_RESULT:
            begin
                cmd.load_out = !sts.out_busy;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: hdl/sad_dp.sv
// Datapath: config registers, raster counters, line stores, SAD accumulator
// and best-match tracking, output register. Depends on sad_pkg.
module sad_dp
    import sad_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int WINDOW    = WINDOW_DEF,
    parameter int SEARCH    = SEARCH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_accept,
    input  logic [PIX_W-1:0]      pix_l,
    input  logic [PIX_W-1:0]      pix_r,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  sad_cmd_t              cmd,
    output sad_sts_t              sts,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DISP_W-1:0]     disparity,
    output logic [ROW_W-1:0]      out_row,
    output logic [COL_W-1:0]      out_col
);

    localparam int LINES = WINDOW + 1;
    localparam int SW    = $clog2(LINES);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int XW    = $clog2(MAX_WIDTH + SEARCH + WINDOW + 1);
    localparam int IW    = $clog2(WINDOW);
    localparam int SADW  = $clog2(WINDOW * WINDOW * 255 + 1);

    // configuration
    logic [IMG_W_W-1:0] img_w_reg;
    logic [IMG_H_W-1:0] img_h_reg;

    // raster position of the next pixel
    logic [ROW_W-1:0] row_reg;
    logic [CW-1:0]    col_reg;
    logic [SW-1:0]    slot_reg;

    // item being processed
    logic [ROW_W-1:0] item_r_reg;
    logic [CW-1:0]    item_c_reg;
    logic [SW-1:0]    item_slot_reg;

    // search state
    logic [CW-1:0]   s_reg;
    logic [IW-1:0]   i_reg;
    logic [IW-1:0]   j_reg;
    logic [SW-1:0]   lslot_reg;
    logic [SADW-1:0] sad_reg;
    logic [SADW-1:0] best_sad_reg;
    logic [CW-1:0]   best_col_reg;
    logic            first_reg;

    // line stores
    logic [PIX_W-1:0] lmem [LINES][MAX_WIDTH];
    logic [PIX_W-1:0] rmem [LINES][MAX_WIDTH];
    logic [PIX_W-1:0] lq_reg;
    logic [PIX_W-1:0] rq_reg;

    // output register
    logic              out_valid_reg;
    logic [DISP_W-1:0] disp_reg;
    logic [ROW_W-1:0]  orow_reg;
    logic [COL_W-1:0]  ocol_reg;

    logic [DIM_CMP_W-1:0] w_req;
    logic [DIM_CMP_W-1:0] h_req;
    logic [DIM_CMP_W-1:0] w_full;
    logic [DIM_CMP_W-1:0] h_full;
    logic [WW-1:0]        w_eff;
    logic [DIM_CMP_W-1:0] h_eff;
    logic                 row_stale;
    logic [ROW_W-1:0]     cur_r;
    logic [CW-1:0]        cur_c;
    logic [SW-1:0]        cur_slot;
    logic [XW-1:0]        c_x;
    logic [XW-1:0]        w_x;
    logic [XW-1:0]        lo_x;
    logic [XW-1:0]        hi_x;
    logic [XW-1:0]        rx_x;
    logic [CW-1:0]        lcol;
    logic [CW-1:0]        rcol;
    logic [SW-1:0]        rslot;
    logic [ROW_W-1:0]     orow;
    logic [PIX_W-1:0]     absd;
    logic [CW-1:0]        disp_full;

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        return (s == SW'(LINES - 1)) ? '0 : s + 1'b1;
    endfunction

    // effective frame size
    always_comb
    begin
        w_req  = DIM_CMP_W'(img_w_reg);
        h_req  = img_h_reg;
        w_full = (w_req < DIM_CMP_W'(MIN_DIM)) ? DIM_CMP_W'(MIN_DIM) :
                 (w_req > DIM_CMP_W'(MAX_WIDTH)) ? DIM_CMP_W'(MAX_WIDTH) : w_req;
        h_full = (h_req < DIM_CMP_W'(MIN_DIM)) ? DIM_CMP_W'(MIN_DIM) :
                 (h_req > DIM_CMP_W'(MAX_HEIGHT)) ? DIM_CMP_W'(MAX_HEIGHT) : h_req;
        w_eff  = WW'(w_full);
        h_eff  = h_full;
    end

    // position of the arriving pixel, stale values folded to zero
    always_comb
    begin
        row_stale = DIM_CMP_W'(row_reg) >= h_eff;
        cur_r     = row_stale ? '0 : row_reg;
        cur_slot  = row_stale ? '0 : slot_reg;
        cur_c     = (WW'(col_reg) >= w_eff) ? '0 : col_reg;
    end

    // config registers and raster counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg <= IMG_W_W'(RESET_WIDTH);
            img_h_reg <= IMG_H_W'(RESET_HEIGHT);
            row_reg   <= '0;
            col_reg   <= '0;
            slot_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  img_w_reg <= cfg_data[IMG_W_W-1:0];
                REG_IMAGE_HEIGHT: img_h_reg <= cfg_data[IMG_H_W-1:0];
                default:          img_w_reg <= img_w_reg;
            endcase
            row_reg  <= '0;
            col_reg  <= '0;
            slot_reg <= '0;
        end
        else if (in_accept)
        begin
            if (WW'(cur_c) + 1'b1 >= w_eff)
            begin
                col_reg <= '0;
                if (DIM_CMP_W'(cur_r) + 1'b1 >= h_eff)
                begin
                    row_reg  <= '0;
                    slot_reg <= '0;
                end
                else
                begin
                    row_reg  <= cur_r + 1'b1;
                    slot_reg <= slot_inc(cur_slot);
                end
            end
            else
            begin
                col_reg  <= cur_c + 1'b1;
                row_reg  <= cur_r;
                slot_reg <= cur_slot;
            end
        end
    end

    // latch the item position
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_r_reg    <= cur_r;
            item_c_reg    <= cur_c;
            item_slot_reg <= cur_slot;
        end
    end

    // search range, store addresses, absolute difference, output row and disparity
    always_comb
    begin
        c_x   = XW'(item_c_reg);
        w_x   = XW'(w_eff);
        lo_x  = (c_x > XW'(SEARCH)) ? c_x - XW'(SEARCH) : '0;
        hi_x  = (c_x + XW'(SEARCH) > w_x) ? w_x : c_x + XW'(SEARCH);
        lcol  = item_c_reg + CW'(j_reg);
        rx_x  = XW'(s_reg) + XW'(j_reg);
        if (rx_x >= w_x)
        begin
            rcol  = CW'(rx_x - w_x);
            rslot = slot_inc(lslot_reg);
        end
        else
        begin
            rcol  = CW'(rx_x);
            rslot = lslot_reg;
        end
        absd = (lq_reg > rq_reg) ? lq_reg - rq_reg : rq_reg - lq_reg;
        orow = item_r_reg - ROW_W'(WINDOW);
        disp_full = (best_col_reg > item_c_reg) ? '0 : item_c_reg - best_col_reg;
    end

    // line stores
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            lmem[cur_slot][cur_c] <= pix_l;
            rmem[cur_slot][cur_c] <= pix_r;
        end
        if (cmd.rd)
        begin
            lq_reg <= lmem[lslot_reg][lcol];
            rq_reg <= rmem[rslot][rcol];
        end
    end

    // search counters, accumulator and best-match tracking
    always_ff @(posedge clk)
    begin
        if (cmd.start_search)
        begin
            s_reg     <= CW'(lo_x);
            first_reg <= 1'b1;
        end
        if (cmd.cand_init)
        begin
            i_reg     <= '0;
            j_reg     <= '0;
            sad_reg   <= '0;
            lslot_reg <= slot_inc(item_slot_reg);
        end
        if (cmd.acc)
        begin
            sad_reg <= sad_reg + SADW'(absd);
            if (j_reg == IW'(WINDOW - 1))
            begin
                j_reg     <= '0;
                i_reg     <= i_reg + 1'b1;
                lslot_reg <= slot_inc(lslot_reg);
            end
            else
            begin
                j_reg <= j_reg + 1'b1;
            end
        end
        if (cmd.cand_done)
        begin
            if (first_reg || sad_reg < best_sad_reg)
            begin
                best_sad_reg <= sad_reg;
                best_col_reg <= s_reg;
            end
            first_reg <= 1'b0;
            s_reg     <= s_reg + 1'b1;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            disp_reg <= sts.need_match ? DISP_W'(disp_full) : '0;
            orow_reg <= orow;
            ocol_reg <= COL_W'(item_c_reg);
        end
    end

    // status
    always_comb
    begin
        sts.need_out   = item_r_reg >= ROW_W'(WINDOW);
        sts.need_match = (orow >= ROW_W'(WINDOW)) && (item_c_reg >= CW'(WINDOW)) &&
                         (WW'(item_c_reg) + WW'(WINDOW) < w_eff);
        sts.last_px    = (i_reg == IW'(WINDOW - 1)) && (j_reg == IW'(WINDOW - 1));
        sts.last_cand  = XW'(s_reg) + 1'b1 >= hi_x;
        sts.out_busy   = out_valid_reg && !out_ready;
    end

    assign out_valid = out_valid_reg;
    assign disparity = disp_reg;
    assign out_row   = orow_reg;
    assign out_col   = ocol_reg;

endmodule

// File: hdl/stereo_sad_disparity.sv
// Top level of the stereo SAD disparity block: controller plus datapath.
// Depends on sad_pkg, sad_if, sad_ctrl and sad_dp.
//
//  channel   role    payload                            handshake
//  pix_in    sink    pix_l, pix_r                       valid/ready
//  res_out   source  disparity, out_row, out_col        valid/ready
//  cfg       sink    index (0 width, 1 height), data    valid/ready
//
// A pixel pair without a result passes ST_IDLE and ST_CHECK; a border result adds
// ST_RESULT. A matched pixel walks N candidate columns (up to 2*SEARCH): ST_CAND,
// then ST_READ and ST_ACC per window pixel (one read port per line store), ST_NEXT.
// A finished result sits in the output register while the next pair is taken.
// Reset is asynchronous, active low; no clearing pass is needed.
module stereo_sad_disparity
    import sad_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int WINDOW    = WINDOW_DEF,
    parameter int SEARCH    = SEARCH_DEF
)
(
    input logic       clk,
    input logic       rst_n,
    sad_pix_if.sink   pix_in,
    sad_res_if.source res_out,
    sad_cfg_if.sink   cfg
);

    sad_cmd_t cmd;
    sad_sts_t sts;
    logic     in_ready;

    assign pix_in.ready = in_ready;
    assign cfg.ready    = 1'b1;

    sad_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pix_in.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sad_dp #(
        .MAX_WIDTH (MAX_WIDTH),
        .WINDOW    (WINDOW),
        .SEARCH    (SEARCH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_accept   (pix_in.valid & in_ready),
        .pix_l       (pix_in.pix_l),
        .pix_r       (pix_in.pix_r),
        .cfg_we      (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (res_out.valid),
        .out_ready   (res_out.ready),
        .disparity   (res_out.disparity),
        .out_row     (res_out.out_row),
        .out_col     (res_out.out_col)
    );

endmodule

// File: hdl/sad_chk.sv
// Port-level checker for stereo_sad_disparity, attached by bind.
// Depends on sad_pkg for field widths.
module sad_chk
    import sad_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF,
    parameter int SEARCH = SEARCH_DEF
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [DISP_W-1:0] disparity,
    input logic [ROW_W-1:0]  out_row,
    input logic [COL_W-1:0]  out_col
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(disparity) &&
        $stable(out_row) && $stable(out_col))
        else $error("result changed while stalled");

    // one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken before the first was checked");

    // disparity stays within the search range
    a_disp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(disparity) <= SEARCH)
        else $error("disparity beyond search range");

    // top and left borders give zero
    a_border: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (32'(out_row) < WINDOW || 32'(out_col) < WINDOW) |-> disparity == '0)
        else $error("non-zero disparity on border");

endmodule

bind stereo_sad_disparity sad_chk #(
    .WINDOW (WINDOW),
    .SEARCH (SEARCH)
) u_sad_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .disparity (res_out.disparity),
    .out_row   (res_out.out_row),
    .out_col   (res_out.out_col)
);
